@@ rtl/tlbf_pkg.sv @@
// ----------------------------------------------------------------------------
// tlbf_pkg
// Types, constants and helpers shared by the translation buffer and its cells.
// ----------------------------------------------------------------------------
package tlbf_pkg;

  localparam int TLB_DEPTH = 8;
  localparam int AGE_WIDTH = 16;
  localparam int IDX_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TLB_DEPTH + 1);
  localparam int MAX_SHIFT = 16;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [AGE_WIDTH-1:0] age_t;
  typedef logic [31:0]          page_t;
  typedef logic [7:0]           pid_t;
  typedef logic [19:0]          frame_t;
  typedef logic [35:0]          paddr_t;
  typedef logic [15:0]          offset_t;
  typedef logic [4:0]           shift_t;
  typedef logic [3:0]           entries_t;

  localparam age_t AGE_MAX = '1;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_FILL      = 1'b1;

  typedef enum logic [1:0] {
    ST_HIT        = 2'd0,
    ST_MISS       = 2'd1,
    ST_FILLED     = 2'd2,
    ST_NO_PENDING = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_SIZE = 2'd0,
    REG_ENTRIES   = 2'd1,
    REG_POLICY    = 2'd2
  } reg_index_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

  typedef struct packed {
    logic   op;
    pid_t   pid;
    page_t  logical_address;
    frame_t frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    page_t      page_number;
    paddr_t     physical_address;
  } out_item_t;

  // Handed from one cell to the next along the row.
  typedef struct packed {
    logic   hit;
    frame_t hit_frame;
    age_t   best_age;
    idx_t   best_idx;
  } link_t;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic   lookup;
    logic   lru;
    logic   fill;
    idx_t   fill_slot;
    cnt_t   live;
    page_t  page;
    pid_t   pid;
    frame_t frame;
  } cmd_t;

  // The offset never reaches the frame bits, so an OR is the sum.
  function automatic paddr_t compose(frame_t f, offset_t o, shift_t sh);
    paddr_t  base;
    offset_t mask;
    base = paddr_t'(f) << sh;
    mask = offset_t'((32'd1 << sh) - 32'd1);
    return base | paddr_t'(o & mask);
  endfunction

endpackage

@@ rtl/tlbf_cell.sv @@
// ----------------------------------------------------------------------------
// tlbf_cell
// One slot of the buffer: holds a tag, a frame and an age, compares against
// the broadcast lookup and passes the hit and victim search to its neighbour.
// ----------------------------------------------------------------------------
module tlbf_cell (
  input  logic             clk,
  input  logic             rst,
  input  tlbf_pkg::idx_t   idx,
  input  tlbf_pkg::cmd_t   cmd,
  input  tlbf_pkg::link_t  link_in,
  output tlbf_pkg::link_t  link_out
);

  tlbf_pkg::page_t  entry_page;
  tlbf_pkg::pid_t   entry_pid;
  tlbf_pkg::frame_t entry_frame;
  tlbf_pkg::age_t   age;
  tlbf_pkg::age_t   age_next;

  logic live_here;
  logic match;
  logic win;
  logic older;
  logic write;

  assign live_here = tlbf_pkg::cnt_t'(idx) < cmd.live;
  assign match     = live_here && (entry_page == cmd.page) && (entry_pid == cmd.pid);
  // Only the lowest matching slot counts as the hit.
  assign win       = match && !link_in.hit;
  assign older     = live_here && (age > link_in.best_age);
  assign write     = cmd.fill && (cmd.fill_slot == idx);

  always_comb begin
    link_out.hit       = link_in.hit | match;
    link_out.hit_frame = link_in.hit ? link_in.hit_frame : entry_frame;
    link_out.best_age  = older ? age : link_in.best_age;
    link_out.best_idx  = older ? idx : link_in.best_idx;
  end

  always_comb begin
    age_next = age;
    if (write) begin
      age_next = '0;
    end else if (cmd.lookup && cmd.lru && live_here) begin
      if (win) begin
        age_next = '0;
      end else if (age != tlbf_pkg::AGE_MAX) begin
        age_next = age + tlbf_pkg::age_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age <= '0;
    end else begin
      age <= age_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      entry_page  <= cmd.page;
      entry_pid   <= cmd.pid;
      entry_frame <= cmd.frame;
    end
  end

endmodule

@@ rtl/tlb_fifo_lru_translate.sv @@
// ----------------------------------------------------------------------------
// tlb_fifo_lru_translate
// Fully associative translation buffer tagged by page and process id, with
// round-robin or age-based replacement.
// ----------------------------------------------------------------------------
// For each item, the cycle of acceptance registers it and splits the address
// into page and offset, and the next cycle runs the row of slot cells, which
// search, age and replace in one pass. The result appears on result with done
// high for one cycle after that, and busy is already low in that cycle, so a
// new item may start while done is high. Results cannot be held off: done
// marks the only cycle in which a result is shown.
module tlb_fifo_lru_translate (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  tlbf_pkg::in_item_t                   request,
  output logic                                 done,
  output tlbf_pkg::out_item_t                  result,
  input  logic                                 cfg_we,
  input  logic [tlbf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlbf_pkg::CFG_W-1:0]           cfg_data
);

  // Configuration
  tlbf_pkg::shift_t   page_size_log2;
  tlbf_pkg::entries_t tlb_entries;
  logic               replace_lru;

  // Control
  tlbf_pkg::fsm_t state;
  tlbf_pkg::fsm_t state_next;
  logic           accept;
  logic           exec;

  // Registered item
  logic             req_op;
  tlbf_pkg::pid_t   req_pid;
  tlbf_pkg::page_t  req_page;
  tlbf_pkg::offset_t req_offset;
  tlbf_pkg::frame_t req_frame;

  // Book-keeping
  tlbf_pkg::cnt_t    filled_count;
  tlbf_pkg::cnt_t    filled_next;
  tlbf_pkg::idx_t    fifo_pointer;
  tlbf_pkg::idx_t    fifo_next;
  logic              pending_valid;
  tlbf_pkg::page_t   pending_page;
  tlbf_pkg::offset_t pending_offset;
  tlbf_pkg::pid_t    pending_pid;

  tlbf_pkg::shift_t    shift;
  tlbf_pkg::cnt_t      slots;
  tlbf_pkg::cnt_t      live;
  tlbf_pkg::idx_t      fill_slot;
  tlbf_pkg::cmd_t      cmd;
  tlbf_pkg::link_t     chain [tlbf_pkg::TLB_DEPTH+1];
  tlbf_pkg::out_item_t result_next;

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size_log2 <= tlbf_pkg::shift_t'(5);
      tlb_entries    <= tlbf_pkg::entries_t'(4);
      replace_lru    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlbf_pkg::REG_PAGE_SIZE: page_size_log2 <= cfg_data;
        tlbf_pkg::REG_ENTRIES:   tlb_entries    <= cfg_data[3:0];
        tlbf_pkg::REG_POLICY:    replace_lru    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    shift = (page_size_log2 > tlbf_pkg::shift_t'(tlbf_pkg::MAX_SHIFT)) ?
            tlbf_pkg::shift_t'(tlbf_pkg::MAX_SHIFT) : page_size_log2;
    if (32'(tlb_entries) > 32'(tlbf_pkg::TLB_DEPTH)) begin
      slots = tlbf_pkg::cnt_t'(tlbf_pkg::TLB_DEPTH);
    end else begin
      slots = tlbf_pkg::cnt_t'(tlb_entries);
    end
    live = (filled_count < slots) ? filled_count : slots;
  end

  // State machine
  always_comb begin
    state_next = state;
    unique case (state)
      tlbf_pkg::S_IDLE: if (start) state_next = tlbf_pkg::S_EXEC;
      tlbf_pkg::S_EXEC: state_next = tlbf_pkg::S_IDLE;
      default:          state_next = tlbf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state == tlbf_pkg::S_EXEC);
    exec   = (state == tlbf_pkg::S_EXEC);
    accept = start && (state == tlbf_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The address is split as the item is taken in.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op     <= request.op;
      req_pid    <= request.pid;
      req_page   <= request.logical_address >> shift;
      req_offset <= tlbf_pkg::offset_t'(request.logical_address &
                                        ((32'd1 << shift) - 32'd1));
      req_frame  <= request.frame;
    end
  end

  // Slot choice for a fill: free slots first, then the policy's victim.
  always_comb begin
    filled_next = filled_count;
    fifo_next   = fifo_pointer;
    fill_slot   = '0;
    if (filled_count < slots) begin
      fill_slot   = tlbf_pkg::idx_t'(filled_count);
      filled_next = filled_count + tlbf_pkg::cnt_t'(1);
    end else begin
      filled_next = slots;
      if (replace_lru) begin
        fill_slot = chain[tlbf_pkg::TLB_DEPTH].best_idx;
      end else begin
        fill_slot = (tlbf_pkg::cnt_t'(fifo_pointer) < slots) ? fifo_pointer : '0;
        fifo_next = ((tlbf_pkg::cnt_t'(fill_slot) + tlbf_pkg::cnt_t'(1)) >= slots) ?
                    '0 : fill_slot + tlbf_pkg::idx_t'(1);
      end
    end
  end

  always_comb begin
    cmd.lookup    = exec && (req_op == tlbf_pkg::OP_TRANSLATE);
    cmd.lru       = replace_lru;
    cmd.fill      = exec && (req_op == tlbf_pkg::OP_FILL) && pending_valid &&
                    (slots != '0);
    cmd.fill_slot = fill_slot;
    cmd.live      = live;
    cmd.page      = (req_op == tlbf_pkg::OP_TRANSLATE) ? req_page : pending_page;
    cmd.pid       = (req_op == tlbf_pkg::OP_TRANSLATE) ? req_pid : pending_pid;
    cmd.frame     = req_frame;
  end

  // Row of slot cells
  assign chain[0] = '0;

  for (genvar g = 0; g < tlbf_pkg::TLB_DEPTH; g++) begin : g_cell
    tlbf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (tlbf_pkg::idx_t'(g)),
      .cmd      (cmd),
      .link_in  (chain[g]),
      .link_out (chain[g+1])
    );
  end

  always_comb begin
    result_next = '0;
    if (req_op == tlbf_pkg::OP_TRANSLATE) begin
      result_next.page_number = req_page;
      if (chain[tlbf_pkg::TLB_DEPTH].hit) begin
        result_next.status           = tlbf_pkg::ST_HIT;
        result_next.physical_address =
          tlbf_pkg::compose(chain[tlbf_pkg::TLB_DEPTH].hit_frame, req_offset, shift);
      end else begin
        result_next.status = tlbf_pkg::ST_MISS;
      end
    end else if (pending_valid) begin
      result_next.status           = tlbf_pkg::ST_FILLED;
      result_next.page_number      = pending_page;
      result_next.physical_address = tlbf_pkg::compose(req_frame, pending_offset, shift);
    end else begin
      result_next.status = tlbf_pkg::ST_NO_PENDING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= 1'b0;
      filled_count  <= '0;
      fifo_pointer  <= '0;
      pending_valid <= 1'b0;
    end else begin
      done <= exec;
      if (cmd.fill) begin
        filled_count <= filled_next;
        fifo_pointer <= fifo_next;
      end
      if (exec) begin
        if (req_op == tlbf_pkg::OP_TRANSLATE) begin
          if (!chain[tlbf_pkg::TLB_DEPTH].hit) begin
            pending_valid <= 1'b1;
          end
        end else begin
          pending_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      result <= result_next;
      if (cmd.lookup && !chain[tlbf_pkg::TLB_DEPTH].hit) begin
        pending_page   <= req_page;
        pending_offset <= req_offset;
        pending_pid    <= req_pid;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item at work");

  a_single_exec: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("item held for more than one execution cycle");

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    32'(filled_count) <= 32'(tlbf_pkg::TLB_DEPTH))
    else $error("fill count beyond buffer depth");

  a_fill_had_pending: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == tlbf_pkg::ST_FILLED)) |-> $past(pending_valid))
    else $error("fill reported without a pending miss");

  a_fill_no_pending: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == tlbf_pkg::ST_NO_PENDING)) |-> !$past(pending_valid))
    else $error("fill rejected although a miss was pending");
`endif

endmodule
